// ----- rtl/h264au_pkg.sv -----
`timescale 1ns / 1ps

package h264au_pkg;

    localparam int UNIT_MAX_DEF      = 65536;
    localparam int PARAM_SET_MAX_DEF = 256;

    // byte banks shared by collect, parameter set, idr and waiting unit roles
    localparam int BANKS = 8;
    localparam int BW    = 3;

    localparam logic [7:0] START_TAIL = 8'h01;
    localparam logic [4:0] KIND_MASK  = 5'h1f;
    localparam logic [4:0] KIND_SPS   = 5'd7;
    localparam logic [4:0] KIND_PPS   = 5'd8;
    localparam logic [4:0] KIND_IDR   = 5'd5;
    localparam logic [4:0] KIND_SLICE = 5'd1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_SLICE = 2'd1,
        PEND_KEY   = 2'd2
    } pend_kind_t;

endpackage

// ----- rtl/h264_annexb_access_unit_assembler.sv -----
`timescale 1ns / 1ps

// channel   handshake             payload
// input     in_valid / in_ready   op, data_byte
// result    res_valid / res_ready out_valid, out_byte, out_last, out_keyframe,
//                                 unit_ready, unit_dropped
//
// one request per cycle, push or pull, taken while in_ready is high; each result is registered
// first in the byte memory read port stage and then in the output register.
// NAL units land in one of eight byte banks; finishing a unit or forming a key unit
// only swaps bank pointers, so no bytes are copied.
// reset clears all control state at once; bank contents are never cleared.
// a full, stalled output register stops intake only once the read stage is also full.

module h264_annexb_access_unit_assembler #(
    parameter int UNIT_MAX      = h264au_pkg::UNIT_MAX_DEF,
    parameter int PARAM_SET_MAX = h264au_pkg::PARAM_SET_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_keyframe,
    output logic       unit_ready,
    output logic       unit_dropped
);

    localparam int AW  = $clog2(UNIT_MAX);
    localparam int LW  = $clog2(UNIT_MAX + 4);
    localparam int PLW = $clog2(PARAM_SET_MAX + 1);
    localparam int BW  = h264au_pkg::BW;

    logic [7:0] mem [h264au_pkg::BANKS][UNIT_MAX];
    logic [7:0] rd_data_reg;

    logic [23:0]   tail_reg, tail_next;
    logic          sync_reg, sync_next;
    logic [LW-1:0] nlen_reg, nlen_next;
    logic [4:0]    kind_reg, kind_next;
    logic          ovf_reg, ovf_next;
    logic [BW-1:0] coll_reg, coll_next;
    logic [BW-1:0] sps_bank_reg, sps_bank_next, pps_bank_reg, pps_bank_next;
    logic [BW-1:0] idr_bank_reg, idr_bank_next;
    logic [PLW-1:0] sps_len_reg, sps_len_next, pps_len_reg, pps_len_next;
    logic [LW-1:0] idr_len_reg, idr_len_next;
    h264au_pkg::pend_kind_t pk_reg, pk_next;
    logic [BW-1:0] pb0_reg, pb0_next, pb1_reg, pb1_next, pb2_reg, pb2_next;
    logic [LW-1:0] pl0_reg, pl0_next, pl1_reg, pl1_next, pl2_reg, pl2_next;
    logic [1:0]    seg_reg, seg_next;
    logic [AW-1:0] off_reg, off_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_ov_reg, s1_last_reg, s1_key_reg, s1_rdy_reg, s1_drop_reg, s1_mem_reg;
    logic [7:0] s1_const_reg;
    logic o_valid_reg;
    logic o_ov_reg, o_last_reg, o_key_reg, o_rdy_reg, o_drop_reg;
    logic [7:0] o_byte_reg;

    logic accept, advance;
    logic wr_en, rd_en;
    logic [AW-1:0] wr_off;
    logic [BW-1:0] rd_bank;
    logic r_ov, r_last, r_key, r_drop, r_mem;
    logic [7:0] r_const;

    logic at_start, do_begin;
    logic [LW-1:0] size;
    logic [LW-1:0] cur_len;
    logic [LW:0]   off_inc;
    logic          last_seg;
    logic [h264au_pkg::BANKS-1:0] in_use;

    assign advance  = !o_valid_reg || res_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tail_next     = tail_reg;
        sync_next     = sync_reg;
        nlen_next     = nlen_reg;
        kind_next     = kind_reg;
        ovf_next      = ovf_reg;
        coll_next     = coll_reg;
        sps_bank_next = sps_bank_reg;
        pps_bank_next = pps_bank_reg;
        idr_bank_next = idr_bank_reg;
        sps_len_next  = sps_len_reg;
        pps_len_next  = pps_len_reg;
        idr_len_next  = idr_len_reg;
        pk_next       = pk_reg;
        pb0_next      = pb0_reg;
        pb1_next      = pb1_reg;
        pb2_next      = pb2_reg;
        pl0_next      = pl0_reg;
        pl1_next      = pl1_reg;
        pl2_next      = pl2_reg;
        seg_next      = seg_reg;
        off_next      = off_reg;
        wr_en         = 1'b0;
        wr_off        = nlen_reg[AW-1:0];
        rd_en         = 1'b0;
        r_ov          = 1'b0;
        r_last        = 1'b0;
        r_key         = 1'b0;
        r_drop        = 1'b0;
        r_mem         = 1'b0;
        r_const       = 8'h00;
        do_begin      = 1'b0;
        in_use        = '0;
        at_start      = (tail_reg == 24'd0) && (data_byte == h264au_pkg::START_TAIL);
        size          = nlen_reg - LW'(3);

        case (seg_reg)
            2'd0:    cur_len = pl0_reg;
            2'd1:    cur_len = pl1_reg;
            default: cur_len = pl2_reg;
        endcase
        case (seg_reg)
            2'd0:    rd_bank = pb0_reg;
            2'd1:    rd_bank = pb1_reg;
            default: rd_bank = pb2_reg;
        endcase
        off_inc  = {{(LW + 1 - AW){1'b0}}, off_reg} + (LW + 1)'(1);
        last_seg = (seg_reg == 2'd2) || (seg_reg == 2'd1 && pl2_reg == '0)
                   || (seg_reg == 2'd0 && pl1_reg == '0 && pl2_reg == '0);

        if (accept && op == h264au_pkg::OP_PUSH)
        begin
            tail_next = {tail_reg[15:0], data_byte};
            if (!sync_reg)
            begin
                if (at_start)
                begin
                    sync_next = 1'b1;
                    do_begin  = 1'b1;
                end
            end
            else if (at_start && nlen_reg >= LW'(7))
            begin
                do_begin = 1'b1;
                if (kind_reg == h264au_pkg::KIND_SPS || kind_reg == h264au_pkg::KIND_PPS)
                begin
                    if (ovf_reg || size > LW'(PARAM_SET_MAX))
                        r_drop = 1'b1;
                    else if (kind_reg == h264au_pkg::KIND_SPS)
                    begin
                        sps_bank_next = coll_reg;
                        sps_len_next  = size[PLW-1:0];
                    end
                    else
                    begin
                        pps_bank_next = coll_reg;
                        pps_len_next  = size[PLW-1:0];
                    end
                end
                else if (kind_reg == h264au_pkg::KIND_IDR)
                begin
                    if (ovf_reg || size > LW'(UNIT_MAX))
                        r_drop = 1'b1;
                    else
                    begin
                        idr_bank_next = coll_reg;
                        idr_len_next  = size;
                    end
                end
                else if (kind_reg == h264au_pkg::KIND_SLICE)
                begin
                    if (ovf_reg || size > LW'(UNIT_MAX) || pk_reg != h264au_pkg::PEND_NONE)
                        r_drop = 1'b1;
                    else
                    begin
                        pk_next  = h264au_pkg::PEND_SLICE;
                        pb0_next = coll_reg;
                        pl0_next = size;
                        pl1_next = '0;
                        pl2_next = '0;
                        seg_next = 2'd0;
                        off_next = '0;
                    end
                end
                if (sps_len_next != '0 && pps_len_next != '0 && idr_len_next != '0)
                begin
                    if (pk_next != h264au_pkg::PEND_NONE)
                        r_drop = 1'b1;
                    else
                    begin
                        pk_next  = h264au_pkg::PEND_KEY;
                        pb0_next = sps_bank_next;
                        pb1_next = pps_bank_next;
                        pb2_next = idr_bank_next;
                        pl0_next = LW'(sps_len_next);
                        pl1_next = LW'(pps_len_next);
                        pl2_next = idr_len_next;
                        seg_next = 2'd0;
                        off_next = '0;
                    end
                    sps_len_next = '0;
                    pps_len_next = '0;
                    idr_len_next = '0;
                end
            end
            else
            begin
                wr_en = (nlen_reg < LW'(UNIT_MAX));
                if (nlen_reg == LW'(4))
                    kind_next = data_byte[4:0] & h264au_pkg::KIND_MASK;
                if (nlen_reg < LW'(UNIT_MAX + 3))
                    nlen_next = nlen_reg + LW'(1);
                else
                    ovf_next = 1'b1;
            end
        end
        else if (accept && pk_reg != h264au_pkg::PEND_NONE)
        begin
            r_ov  = 1'b1;
            r_key = (pk_reg == h264au_pkg::PEND_KEY);
            if (off_reg < AW'(3))
                r_const = 8'h00;
            else if (off_reg == AW'(3))
                r_const = h264au_pkg::START_TAIL;
            else
            begin
                r_mem = 1'b1;
                rd_en = 1'b1;
            end
            if (off_inc >= {1'b0, cur_len})
            begin
                off_next = '0;
                if (last_seg)
                begin
                    r_last   = 1'b1;
                    pk_next  = h264au_pkg::PEND_NONE;
                    seg_next = 2'd0;
                end
                else
                    seg_next = seg_reg + 2'd1;
            end
            else
                off_next = off_inc[AW-1:0];
        end

        // a new unit starts collecting into the lowest bank no other role holds
        if (do_begin)
        begin
            nlen_next = LW'(4);
            kind_next = '0;
            ovf_next  = 1'b0;
            if (sps_len_next != '0)
                in_use[sps_bank_next] = 1'b1;
            if (pps_len_next != '0)
                in_use[pps_bank_next] = 1'b1;
            if (idr_len_next != '0)
                in_use[idr_bank_next] = 1'b1;
            if (pk_next != h264au_pkg::PEND_NONE)
                in_use[pb0_next] = 1'b1;
            if (pk_next == h264au_pkg::PEND_KEY)
            begin
                in_use[pb1_next] = 1'b1;
                in_use[pb2_next] = 1'b1;
            end
            for (int i = h264au_pkg::BANKS - 1; i >= 0; i--)
            begin
                if (!in_use[i])
                    coll_next = BW'(i);
            end
        end

        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[coll_reg][wr_off] <= data_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_bank][off_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= '0;
            sync_reg     <= 1'b0;
            nlen_reg     <= '0;
            kind_reg     <= '0;
            ovf_reg      <= 1'b0;
            coll_reg     <= '0;
            sps_bank_reg <= '0;
            pps_bank_reg <= '0;
            idr_bank_reg <= '0;
            sps_len_reg  <= '0;
            pps_len_reg  <= '0;
            idr_len_reg  <= '0;
            pk_reg       <= h264au_pkg::PEND_NONE;
            pb0_reg      <= '0;
            pb1_reg      <= '0;
            pb2_reg      <= '0;
            pl0_reg      <= '0;
            pl1_reg      <= '0;
            pl2_reg      <= '0;
            seg_reg      <= '0;
            off_reg      <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            tail_reg     <= tail_next;
            sync_reg     <= sync_next;
            nlen_reg     <= nlen_next;
            kind_reg     <= kind_next;
            ovf_reg      <= ovf_next;
            coll_reg     <= coll_next;
            sps_bank_reg <= sps_bank_next;
            pps_bank_reg <= pps_bank_next;
            idr_bank_reg <= idr_bank_next;
            sps_len_reg  <= sps_len_next;
            pps_len_reg  <= pps_len_next;
            idr_len_reg  <= idr_len_next;
            pk_reg       <= pk_next;
            pb0_reg      <= pb0_next;
            pb1_reg      <= pb1_next;
            pb2_reg      <= pb2_next;
            pl0_reg      <= pl0_next;
            pl1_reg      <= pl1_next;
            pl2_reg      <= pl2_next;
            seg_reg      <= seg_next;
            off_reg      <= off_next;
            s1_valid_reg <= s1_valid_next;
            if (advance)
                o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ov_reg    <= r_ov;
            s1_last_reg  <= r_last;
            s1_key_reg   <= r_key;
            s1_rdy_reg   <= (pk_next != h264au_pkg::PEND_NONE);
            s1_drop_reg  <= r_drop;
            s1_mem_reg   <= r_mem;
            s1_const_reg <= r_const;
        end
        if (advance && s1_valid_reg)
        begin
            o_ov_reg   <= s1_ov_reg;
            o_byte_reg <= s1_mem_reg ? rd_data_reg : s1_const_reg;
            o_last_reg <= s1_last_reg;
            o_key_reg  <= s1_key_reg;
            o_rdy_reg  <= s1_rdy_reg;
            o_drop_reg <= s1_drop_reg;
        end
    end

    assign res_valid    = o_valid_reg;
    assign out_valid    = o_ov_reg;
    assign out_byte     = o_byte_reg;
    assign out_last     = o_last_reg;
    assign out_keyframe = o_key_reg;
    assign unit_ready   = o_rdy_reg;
    assign unit_dropped = o_drop_reg;

endmodule
